[sv/assert_macros.svh]
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[sv/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared widths, codes, constants and controller/datapath types of the
// text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int TYPE_W = 3;
  localparam int CHAR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int NIB_W  = 4;
  localparam int POS_W  = 11;

  // request codes
  localparam logic [TYPE_W-1:0] REQ_PUT_CHAR  = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_READ_CELL = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_CLEAR     = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_SET_COLOR = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_MOVE      = 3'd4;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] GLYPH_SPACE  = 8'h20;

  localparam logic [CHAR_W-1:0] ATTR_RESET = 8'h80;
  localparam logic [CHAR_W-1:0] ATTR_CLEAR = 8'h0F;

  typedef struct packed {
    logic load_req;
    logic put_char;
    logic rd_cell;
    logic set_attr;
    logic move_cursor;
    logic clear_start;
    logic rd_scroll;
    logic wr_scroll;
    logic wr_fill;
    logic fill_blank;
    logic idx_clr;
    logic idx_inc;
    logic idx_set_bot;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [TYPE_W-1:0] req_type;
    logic              scroll_needed;
    logic              idx_last;
    logic              idx_scr_last;
    logic              out_free;
  } stat_t;

endpackage

[sv/tcw_ifs.sv]
// ----------------------------------------------------------------------------
// tcw request and response channels
// Valid/ready channels carrying one console request and one result.
// ----------------------------------------------------------------------------
interface tcw_req_if;
  logic                         valid;
  logic                         ready;
  logic [tcw_pkg::TYPE_W-1:0]   req_type;
  logic [tcw_pkg::CHAR_W-1:0]   char_code;
  logic [tcw_pkg::COL_W-1:0]    col;
  logic [tcw_pkg::ROW_W-1:0]    row;
  logic [tcw_pkg::NIB_W-1:0]    foreground;
  logic [tcw_pkg::NIB_W-1:0]    background;

  modport source (output valid, req_type, char_code, col, row, foreground, background,
                  input ready);
  modport sink (input valid, req_type, char_code, col, row, foreground, background,
                output ready);
endinterface

interface tcw_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [tcw_pkg::CHAR_W-1:0]   cell_char;
  logic [tcw_pkg::CHAR_W-1:0]   cell_attr;
  logic [tcw_pkg::COL_W-1:0]    cursor_col;
  logic [tcw_pkg::ROW_W-1:0]    cursor_row;
  logic [tcw_pkg::POS_W-1:0]    cursor_pos;

  modport source (output valid, cell_char, cell_attr, cursor_col, cursor_row, cursor_pos,
                  input ready);
  modport sink (input valid, cell_char, cell_attr, cursor_col, cursor_row, cursor_pos,
                output ready);
endinterface

[sv/tcw_ctrl.sv]
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer: reset clearing pass, request decode, scroll copy, screen clear
// and result hand-off.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  tcw_pkg::stat_t stat,
  output tcw_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_INIT     = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_EXEC     = 3'd2;
  localparam logic [2:0] S_SCR_RD   = 3'd3;
  localparam logic [2:0] S_SCR_WR   = 3'd4;
  localparam logic [2:0] S_FILL_BOT = 3'd5;
  localparam logic [2:0] S_CLEAR    = 3'd6;
  localparam logic [2:0] S_RESP     = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_INIT: begin
        cmd.wr_fill = 1'b1;
        if (stat.idx_last) begin
          cmd.idx_clr = 1'b1;
          state_next  = S_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.idx_clr = 1'b1;
        state_next  = S_RESP;
        case (stat.req_type)
          tcw_pkg::REQ_PUT_CHAR: begin
            cmd.put_char = 1'b1;
            if (stat.scroll_needed) begin
              state_next = S_SCR_RD;
            end
          end
          tcw_pkg::REQ_READ_CELL: cmd.rd_cell = 1'b1;
          tcw_pkg::REQ_CLEAR: begin
            cmd.clear_start = 1'b1;
            state_next      = S_CLEAR;
          end
          tcw_pkg::REQ_SET_COLOR: cmd.set_attr = 1'b1;
          tcw_pkg::REQ_MOVE:      cmd.move_cursor = 1'b1;
          default: ;
        endcase
      end
      S_SCR_RD: begin
        cmd.rd_scroll = 1'b1;
        state_next    = S_SCR_WR;
      end
      S_SCR_WR: begin
        cmd.wr_scroll = 1'b1;
        if (stat.idx_scr_last) begin
          cmd.idx_set_bot = 1'b1;
          state_next      = S_FILL_BOT;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SCR_RD;
        end
      end
      S_FILL_BOT: begin
        cmd.wr_fill = 1'b1;
        if (stat.idx_last) begin
          cmd.idx_clr = 1'b1;
          state_next  = S_RESP;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_CLEAR: begin
        cmd.wr_fill    = 1'b1;
        cmd.fill_blank = 1'b1;
        if (stat.idx_last) begin
          cmd.idx_clr = 1'b1;
          state_next  = S_RESP;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_RESP: begin
        // hold until the output register is free
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

endmodule

[sv/tcw_datapath.sv]
// ----------------------------------------------------------------------------
// tcw_datapath
// Cell store, cursor, attribute, sweep index and result register.
// ----------------------------------------------------------------------------
module tcw_datapath #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  tcw_pkg::cmd_t              cmd,
  output tcw_pkg::stat_t             stat,
  input  logic [tcw_pkg::TYPE_W-1:0] req_type,
  input  logic [tcw_pkg::CHAR_W-1:0] char_code,
  input  logic [tcw_pkg::COL_W-1:0]  col,
  input  logic [tcw_pkg::ROW_W-1:0]  row,
  input  logic [tcw_pkg::NIB_W-1:0]  foreground,
  input  logic [tcw_pkg::NIB_W-1:0]  background,
  tcw_rsp_if.source                  rsp
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int LW    = (AW > tcw_pkg::POS_W) ? AW : tcw_pkg::POS_W;

  // latched request
  logic [tcw_pkg::TYPE_W-1:0] rq_type;
  logic [tcw_pkg::CHAR_W-1:0] rq_char;
  logic [tcw_pkg::COL_W-1:0]  rq_col;
  logic [tcw_pkg::ROW_W-1:0]  rq_row;
  logic [tcw_pkg::NIB_W-1:0]  rq_fg;
  logic [tcw_pkg::NIB_W-1:0]  rq_bg;

  logic [tcw_pkg::COL_W-1:0]  cur_col;
  logic [tcw_pkg::ROW_W-1:0]  cur_line;
  logic [tcw_pkg::CHAR_W-1:0] attr;
  logic [AW-1:0]              idx;

  logic [15:0] mem [CELLS];
  logic [15:0] rdata;
  logic        rd_hit;

  logic                       out_valid;
  logic [tcw_pkg::CHAR_W-1:0] out_char;
  logic [tcw_pkg::CHAR_W-1:0] out_attr;
  logic [tcw_pkg::COL_W-1:0]  out_col;
  logic [tcw_pkg::ROW_W-1:0]  out_row;
  logic [tcw_pkg::POS_W-1:0]  out_pos;

  logic [LW-1:0] cur_lin;
  logic [LW-1:0] req_lin;
  logic          req_in_range;

  logic                      is_nl;
  logic                      is_cr;
  logic                      is_bs;
  logic                      is_glyph;
  logic [tcw_pkg::COL_W:0]   col_step;
  logic                      wrap;
  logic [tcw_pkg::ROW_W:0]   line_step;
  logic                      scroll;
  logic [tcw_pkg::COL_W-1:0] pc_col;
  logic [tcw_pkg::ROW_W-1:0] pc_line;

  logic          we;
  logic [AW-1:0] wa;
  logic [15:0]   wd;
  logic          re;
  logic [AW-1:0] ra;

  assign cur_lin = LW'(cur_line) * LW'(COLUMNS) + LW'(cur_col);
  assign req_lin = LW'(rq_row) * LW'(COLUMNS) + LW'(rq_col);
  assign req_in_range = ({1'b0, rq_col} < (tcw_pkg::COL_W+1)'(COLUMNS)) &&
                        ({1'b0, rq_row} < (tcw_pkg::ROW_W+1)'(ROWS));

  // put-char cursor motion
  always_comb begin
    is_nl    = (rq_char == tcw_pkg::CH_NEWLINE);
    is_cr    = (rq_char == tcw_pkg::CH_RETURN);
    is_bs    = (rq_char == tcw_pkg::CH_BACKSPACE) && (cur_col != '0);
    is_glyph = !is_nl && !is_cr && !is_bs;
    if (is_nl || is_cr) begin
      col_step = '0;
    end else if (is_bs) begin
      col_step = {1'b0, cur_col} - 1'b1;
    end else begin
      col_step = {1'b0, cur_col} + 1'b1;
    end
    wrap      = col_step > (tcw_pkg::COL_W+1)'(COLUMNS - 1);
    line_step = {1'b0, cur_line} + {{tcw_pkg::ROW_W{1'b0}}, (is_nl || wrap)};
    scroll    = line_step > (tcw_pkg::ROW_W+1)'(ROWS - 1);
    pc_col    = (scroll || wrap) ? '0 : col_step[tcw_pkg::COL_W-1:0];
    pc_line   = scroll ? tcw_pkg::ROW_W'(ROWS - 1) : line_step[tcw_pkg::ROW_W-1:0];
  end

  always_comb begin
    stat.req_type      = rq_type;
    stat.scroll_needed = scroll;
    stat.idx_last      = (idx == AW'(CELLS - 1));
    stat.idx_scr_last  = (idx == AW'(CELLS - COLUMNS - 1));
    stat.out_free      = !out_valid || rsp.ready;
  end

  // memory port selection
  always_comb begin
    we = 1'b0;
    wa = idx;
    wd = '0;
    if (cmd.put_char) begin
      we = is_glyph;
      wa = cur_lin[AW-1:0];
      wd = {attr, rq_char};
    end else if (cmd.wr_scroll) begin
      we = 1'b1;
      wd = rdata;
    end else if (cmd.wr_fill) begin
      we = 1'b1;
      wd = cmd.fill_blank ? {tcw_pkg::ATTR_CLEAR, tcw_pkg::GLYPH_SPACE} : 16'h0000;
    end
    re = (cmd.rd_cell && req_in_range) || cmd.rd_scroll;
    ra = cmd.rd_scroll ? (idx + AW'(COLUMNS)) : req_lin[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rdata <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      rq_type <= req_type;
      rq_char <= char_code;
      rq_col  <= col;
      rq_row  <= row;
      rq_fg   <= foreground;
      rq_bg   <= background;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col  <= '0;
      cur_line <= '0;
      attr     <= tcw_pkg::ATTR_RESET;
    end else if (cmd.put_char) begin
      cur_col  <= pc_col;
      cur_line <= pc_line;
    end else if (cmd.clear_start) begin
      cur_col  <= '0;
      cur_line <= '0;
      attr     <= tcw_pkg::ATTR_CLEAR;
    end else if (cmd.set_attr) begin
      attr <= {rq_bg, rq_fg};
    end else if (cmd.move_cursor) begin
      cur_col  <= ({1'b0, rq_col} > (tcw_pkg::COL_W+1)'(COLUMNS - 1)) ?
                  tcw_pkg::COL_W'(COLUMNS - 1) : rq_col;
      cur_line <= ({1'b0, rq_row} > (tcw_pkg::ROW_W+1)'(ROWS - 1)) ?
                  tcw_pkg::ROW_W'(ROWS - 1) : rq_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_set_bot) begin
      idx <= AW'(CELLS - COLUMNS);
    end else if (cmd.idx_inc) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_hit <= 1'b0;
    end else if (cmd.load_req) begin
      rd_hit <= 1'b0;
    end else if (cmd.rd_cell) begin
      rd_hit <= req_in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_char <= rd_hit ? rdata[7:0] : '0;
      out_attr <= rd_hit ? rdata[15:8] : '0;
      out_col  <= cur_col;
      out_row  <= cur_line;
      out_pos  <= cur_lin[tcw_pkg::POS_W-1:0];
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.cell_char  = out_char;
  assign rsp.cell_attr  = out_attr;
  assign rsp.cursor_col = out_col;
  assign rsp.cursor_row = out_row;
  assign rsp.cursor_pos = out_pos;

endmodule

[sv/text_console_writer.sv]
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console: cell store, cursor and attribute behind two channels.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request item (put char, read cell, clear, set color,
//   move cursor); rsp returns exactly one result item per request with the
//   read cell (zero unless a read hits the screen) and the cursor after it.
//   Items are worked one at a time: a plain request passes from accept
//   through execute to the load of its result into the output register,
//   and the next request is not accepted before that load. A put char
//   that scrolls first copies every moved cell up one row, a read then a
//   write per cell, then zeroes the bottom row. A clear writes a space in
//   attribute 0x0F to every cell.
//   After reset the cell store is zeroed one cell per cycle: req.ready stays
//   low until every cell is written. The cursor resets to 0,0 and the
//   attribute to 0x80. A result waiting in the output register does not
//   block the next accept; if rsp stays stalled, the following result holds
//   in the controller until the register frees.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input logic       clk,
  input logic       rst,
  tcw_req_if.sink   req,
  tcw_rsp_if.source rsp
);

  tcw_pkg::cmd_t  cmd;
  tcw_pkg::stat_t stat;
  logic           in_ready;

  assign req.ready = in_ready;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .req_type   (req.req_type),
    .char_code  (req.char_code),
    .col        (req.col),
    .row        (req.row),
    .foreground (req.foreground),
    .background (req.background),
    .rsp        (rsp)
  );

  `ASSERT_IMPLIES(a_cursor_in_range, clk, rst, rsp.valid,
    ({1'b0, rsp.cursor_col} < (tcw_pkg::COL_W+1)'(COLUMNS)) &&
    ({1'b0, rsp.cursor_row} < (tcw_pkg::ROW_W+1)'(ROWS)))
  `ASSERT_NEXT(a_one_item_at_a_time, clk, rst, req.valid && req.ready, !req.ready)
  `ASSERT_IMPLIES(a_no_load_into_full, clk, rst, cmd.load_out, stat.out_free)

endmodule
